FILE: sv/pcr_pkg.sv
// Package for the pair collision resolver: payload structs, register
// indexes, reset values and fixed field widths. Depends on nothing.
package pcr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int GAIN_W        = 18;
  localparam int POS_W         = 32;
  localparam int RAD_W         = 24;
  localparam int CFG_IDX_W     = 1;
  localparam int FAR_LIMIT     = 33554432;

  localparam logic [GAIN_W-1:0] SPRING_RESET  = 18'd32768;
  localparam logic [GAIN_W-1:0] DAMPING_RESET = 18'd6554;

  localparam logic [CFG_IDX_W-1:0] REG_SPRING  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] a_pos_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic signed [POS_W-1:0] a_prev_x;
    logic signed [POS_W-1:0] a_prev_y;
    logic        [RAD_W-1:0] a_radius;
    logic signed [POS_W-1:0] b_pos_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic signed [POS_W-1:0] b_prev_x;
    logic signed [POS_W-1:0] b_prev_y;
    logic        [RAD_W-1:0] b_radius;
  } pcr_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] a_new_pos_x;
    logic signed [POS_W-1:0] a_new_pos_y;
    logic signed [POS_W-1:0] a_new_prev_x;
    logic signed [POS_W-1:0] a_new_prev_y;
    logic signed [POS_W-1:0] b_new_pos_x;
    logic signed [POS_W-1:0] b_new_pos_y;
    logic signed [POS_W-1:0] b_new_prev_x;
    logic signed [POS_W-1:0] b_new_prev_y;
    logic                    hit;
  } pcr_out_t;

endpackage

FILE: sv/pair_collision_resolve.sv
// Pair collision resolver top level: a single deep pipeline with a pipelined
// square root, two pipelined dividers and the impulse multipliers.
// Depends on pcr_pkg.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | pcr_in_t  (one candidate pair)
//   out_    | output    | out_valid/out_stall | pcr_out_t (resolved pair, hit)
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One request enters per cycle while the output is not stalled. The longest
// sections are the 13-stage square root (two root bits a stage) and the divider
// (one quotient bit a stage, FRAC_BITS + 1 stages).
// rst_n clears the valid bits and loads the gain reset values.
// The whole pipeline holds while a result is stalled at the output.
module pair_collision_resolve
  import pcr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pcr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcr_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_wdata
);

  localparam int F      = FRAC_BITS;
  localparam int MW     = 25;                 // magnitude of a near difference
  localparam int RW     = 26;                 // root width
  localparam int RMW    = RW + 3;             // root remainder width
  localparam int SQ_PER = 2;
  localparam int SQ_ST  = RW / SQ_PER;
  localparam int QW     = F + 1;              // quotient bits, |n| <= 1.0
  localparam int DV_ST  = QW;
  localparam int NW     = F + 2;              // signed normal width
  localparam int RVW    = 34;
  localparam int SPP    = GAIN_W + MW;        // spring product width
  localparam int SPW    = SPP - F;
  localparam int PXW    = RVW + NW;
  localparam int VNW    = PXW + 1 - F;
  localparam int DPW    = GAIN_W + 1 + VNW;
  localparam int IMW    = DPW - F;
  localparam int IXW    = IMW + NW;
  localparam int HXW    = RAD_W + 1 + NW;
  localparam int SW     = IXW + 2;
  localparam int S4_I   = 3 + SQ_ST;
  localparam int P0_I   = S4_I + 1 + DV_ST;
  localparam int NST    = P0_I + 7;

  localparam logic signed [32:0]   FAR_P = 33'(FAR_LIMIT);
  localparam logic signed [32:0]   FAR_N = -FAR_P;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

  typedef struct packed {
    pcr_in_t                 pl;
    logic                    near;
    logic [MW-1:0]           rsum;
    logic signed [RVW-1:0]   rvx;
    logic signed [RVW-1:0]   rvy;
    logic [MW-1:0]           adx;
    logic [MW-1:0]           ady;
    logic                    sx;
    logic                    sy;
  } carry_t;

  typedef struct packed {
    carry_t                  c;
    logic [2*MW-1:0]         sqx;
    logic [2*MW-1:0]         sqy;
  } s2_t;

  typedef struct packed {
    carry_t                  c;
    logic [2*MW:0]           d2;
  } s3_t;

  typedef struct packed {
    carry_t                  c;
    logic [2*RW-1:0]         rad;
    logic [RMW-1:0]          rem;
    logic [RW-1:0]           root;
  } sq_t;

  typedef struct packed {
    carry_t                  c;
    logic                    hit;
    logic [MW-1:0]           overlap;
    logic [RW-1:0]           dlen;
  } s4_t;

  typedef struct packed {
    carry_t                  c;
    logic                    hit;
    logic [MW-1:0]           overlap;
    logic [RW-1:0]           dlen;
    logic [SPP-1:0]          spring_p;
    logic [RW-1:0]           remx;
    logic [RW-1:0]           remy;
    logic [QW-1:0]           nbx;
    logic [QW-1:0]           nby;
    logic [QW-1:0]           qx;
    logic [QW-1:0]           qy;
  } dv_t;

  typedef struct packed {
    pcr_in_t                 pl;
    logic                    hit;
    logic signed [NW-1:0]    nx;
    logic signed [NW-1:0]    ny;
    logic [RAD_W-1:0]        half;
  } tl_t;

  typedef struct packed {
    tl_t                     t;
    logic signed [RVW-1:0]   rvx;
    logic signed [RVW-1:0]   rvy;
    logic [SPW-1:0]          spring;
  } p0_t;

  typedef struct packed {
    tl_t                     t;
    logic signed [PXW-1:0]   px;
    logic signed [PXW-1:0]   py;
    logic [SPW-1:0]          spring;
  } p1_t;

  typedef struct packed {
    tl_t                     t;
    logic signed [VNW-1:0]   vn;
    logic [SPW-1:0]          spring;
  } p2_t;

  typedef struct packed {
    tl_t                     t;
    logic signed [DPW-1:0]   damp_p;
    logic [SPW-1:0]          spring;
  } p3_t;

  typedef struct packed {
    tl_t                     t;
    logic signed [IMW-1:0]   imp;
  } p4_t;

  typedef struct packed {
    tl_t                     t;
    logic signed [IXW-1:0]   ix;
    logic signed [IXW-1:0]   iy;
    logic signed [HXW-1:0]   hx;
    logic signed [HXW-1:0]   hy;
  } p5_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SW-1:0] v);
    if (v > SAT_MAX) begin
      return POS_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      return POS_W'(SAT_MIN);
    end
    return POS_W'(v);
  endfunction

  logic [GAIN_W-1:0] spring_gain_r, damping_gain_r;
  logic [NST-1:0]    vld_r, vld_nxt;
  logic              adv;

  carry_t   s1_r, s1_nxt;
  s2_t      s2_r, s2_nxt;
  s3_t      s3_r, s3_nxt;
  sq_t      sq_r [SQ_ST];
  sq_t      sq_nxt [SQ_ST];
  sq_t      sq_in [SQ_ST];
  s4_t      s4_r, s4_nxt;
  dv_t      dv_r [DV_ST];
  dv_t      dv_nxt [DV_ST];
  dv_t      dv_in [DV_ST];
  p0_t      p0_r, p0_nxt;
  p1_t      p1_r, p1_nxt;
  p2_t      p2_r, p2_nxt;
  p3_t      p3_r, p3_nxt;
  p4_t      p4_r, p4_nxt;
  p5_t      p5_r, p5_nxt;
  pcr_out_t out_r, out_nxt;

  // Advance the whole pipeline unless the output request is held
  assign adv       = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;
  assign vld_nxt   = {vld_r[NST-2:0], in_valid};

  // Gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_gain_r  <= SPRING_RESET;
      damping_gain_r <= DAMPING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPRING:  spring_gain_r  <= cfg_wdata;
        REG_DAMPING: damping_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: differences, far check, radius sum, relative velocity
  always_comb begin
    logic signed [32:0] dxw, dyw;
    dxw = 33'(in_data.a_pos_x) - 33'(in_data.b_pos_x);
    dyw = 33'(in_data.a_pos_y) - 33'(in_data.b_pos_y);
    s1_nxt.pl   = in_data;
    s1_nxt.near = (dxw > FAR_N) && (dxw < FAR_P) && (dyw > FAR_N) && (dyw < FAR_P);
    s1_nxt.rsum = MW'(in_data.a_radius) + MW'(in_data.b_radius);
    s1_nxt.sx   = dxw[32];
    s1_nxt.sy   = dyw[32];
    s1_nxt.adx  = dxw[32] ? MW'(-dxw) : MW'(dxw);
    s1_nxt.ady  = dyw[32] ? MW'(-dyw) : MW'(dyw);
    s1_nxt.rvx  = (RVW'(in_data.a_pos_x) - RVW'(in_data.a_prev_x))
                - (RVW'(in_data.b_pos_x) - RVW'(in_data.b_prev_x));
    s1_nxt.rvy  = (RVW'(in_data.a_pos_y) - RVW'(in_data.a_prev_y))
                - (RVW'(in_data.b_pos_y) - RVW'(in_data.b_prev_y));
  end

  // Stage 2: squares of the center difference
  always_comb begin
    s2_nxt.c   = s1_r;
    s2_nxt.sqx = s1_r.adx * s1_r.adx;
    s2_nxt.sqy = s1_r.ady * s1_r.ady;
  end

  // Stage 3: squared distance
  always_comb begin
    s3_nxt.c  = s2_r.c;
    s3_nxt.d2 = (2*MW+1)'(s2_r.sqx) + (2*MW+1)'(s2_r.sqy);
  end

  // Square root: two root bits per stage
  always_comb begin
    sq_in[0].c    = s3_r.c;
    sq_in[0].rad  = (2*RW)'(s3_r.d2);
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
  end

  for (genvar g = 0; g < SQ_ST; g++) begin : g_sq
    if (g > 0) begin : g_link
      assign sq_in[g] = sq_r[g-1];
    end

    always_comb begin
      logic [RMW-1:0] r2, trial;
      sq_nxt[g] = sq_in[g];
      for (int k = 0; k < SQ_PER; k++) begin
        r2    = {sq_nxt[g].rem[RMW-3:0], sq_nxt[g].rad[2*RW-1 -: 2]};
        trial = {1'b0, sq_nxt[g].root, 2'b01};
        sq_nxt[g].rad = {sq_nxt[g].rad[2*RW-3:0], 2'b00};
        if (r2 >= trial) begin
          sq_nxt[g].rem  = r2 - trial;
          sq_nxt[g].root = {sq_nxt[g].root[RW-2:0], 1'b1};
        end else begin
          sq_nxt[g].rem  = r2;
          sq_nxt[g].root = {sq_nxt[g].root[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[g] <= sq_nxt[g];
      end
    end
  end

  // Stage 4: hit test and overlap
  always_comb begin
    logic [RW-1:0] dlen;
    dlen           = sq_r[SQ_ST-1].root;
    s4_nxt.c       = sq_r[SQ_ST-1].c;
    s4_nxt.dlen    = dlen;
    s4_nxt.hit     = sq_r[SQ_ST-1].c.near && (dlen != '0)
                  && (dlen < RW'(sq_r[SQ_ST-1].c.rsum));
    s4_nxt.overlap = sq_r[SQ_ST-1].c.rsum - MW'(dlen);
  end

  // Divider load: first remainder and the numerator bits still to feed
  always_comb begin
    dv_in[0].c        = s4_r.c;
    dv_in[0].hit      = s4_r.hit;
    dv_in[0].overlap  = s4_r.overlap;
    dv_in[0].dlen     = s4_r.dlen;
    dv_in[0].spring_p = SPP'(spring_gain_r) * SPP'(s4_r.overlap);
    dv_in[0].remx     = RW'(s4_r.c.adx[MW-1:1]);
    dv_in[0].remy     = RW'(s4_r.c.ady[MW-1:1]);
    dv_in[0].nbx      = {s4_r.c.adx[0], {F{1'b0}}};
    dv_in[0].nby      = {s4_r.c.ady[0], {F{1'b0}}};
    dv_in[0].qx       = '0;
    dv_in[0].qy       = '0;
  end

  // Normal division: one quotient bit per stage, x and y side by side
  for (genvar g = 0; g < DV_ST; g++) begin : g_dv
    if (g > 0) begin : g_link
      assign dv_in[g] = dv_r[g-1];
    end

    always_comb begin
      logic [RW:0] rx, ry, dd;
      dv_nxt[g] = dv_in[g];
      dd = {1'b0, dv_in[g].dlen};
      rx = {dv_in[g].remx, dv_in[g].nbx[QW-1]};
      ry = {dv_in[g].remy, dv_in[g].nby[QW-1]};
      dv_nxt[g].nbx = dv_in[g].nbx << 1;
      dv_nxt[g].nby = dv_in[g].nby << 1;
      if (rx >= dd) begin
        dv_nxt[g].remx = RW'(rx - dd);
        dv_nxt[g].qx   = {dv_in[g].qx[QW-2:0], 1'b1};
      end else begin
        dv_nxt[g].remx = RW'(rx);
        dv_nxt[g].qx   = {dv_in[g].qx[QW-2:0], 1'b0};
      end
      if (ry >= dd) begin
        dv_nxt[g].remy = RW'(ry - dd);
        dv_nxt[g].qy   = {dv_in[g].qy[QW-2:0], 1'b1};
      end else begin
        dv_nxt[g].remy = RW'(ry);
        dv_nxt[g].qy   = {dv_in[g].qy[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[g] <= dv_nxt[g];
      end
    end
  end

  // Tail 0: signed normal, spring term, half overlap
  always_comb begin
    dv_t d;
    logic signed [NW-1:0] qxs, qys;
    d   = dv_r[DV_ST-1];
    qxs = $signed(NW'(d.qx));
    qys = $signed(NW'(d.qy));
    p0_nxt.t.pl   = d.c.pl;
    p0_nxt.t.hit  = d.hit;
    p0_nxt.t.nx   = d.c.sx ? -qxs : qxs;
    p0_nxt.t.ny   = d.c.sy ? -qys : qys;
    p0_nxt.t.half = d.overlap[MW-1:1];
    p0_nxt.rvx    = d.c.rvx;
    p0_nxt.rvy    = d.c.rvy;
    p0_nxt.spring = d.spring_p[SPP-1:F];
  end

  // Tail 1: velocity projections
  always_comb begin
    p1_nxt.t      = p0_r.t;
    p1_nxt.spring = p0_r.spring;
    p1_nxt.px     = PXW'(p0_r.rvx) * PXW'(p0_r.t.nx);
    p1_nxt.py     = PXW'(p0_r.rvy) * PXW'(p0_r.t.ny);
  end

  // Tail 2: normal relative velocity
  always_comb begin
    logic signed [PXW:0] sm;
    sm = (PXW+1)'(p1_r.px) + (PXW+1)'(p1_r.py);
    p2_nxt.t      = p1_r.t;
    p2_nxt.spring = p1_r.spring;
    p2_nxt.vn     = VNW'(sm >>> F);
  end

  // Tail 3: damping product
  always_comb begin
    p3_nxt.t      = p2_r.t;
    p3_nxt.spring = p2_r.spring;
    p3_nxt.damp_p = DPW'($signed({1'b0, damping_gain_r})) * DPW'(p2_r.vn);
  end

  // Tail 4: impulse, halved
  always_comb begin
    logic signed [IMW:0] diff;
    diff = (IMW+1)'($signed({1'b0, p3_r.spring})) - (IMW+1)'(p3_r.damp_p >>> F);
    p4_nxt.t   = p3_r.t;
    p4_nxt.imp = IMW'(diff >>> 1);
  end

  // Tail 5: impulse and separation vectors
  always_comb begin
    logic signed [HXW-1:0] hs;
    hs = HXW'($signed({1'b0, p4_r.t.half}));
    p5_nxt.t  = p4_r.t;
    p5_nxt.ix = IXW'(p4_r.imp) * IXW'(p4_r.t.nx);
    p5_nxt.iy = IXW'(p4_r.imp) * IXW'(p4_r.t.ny);
    p5_nxt.hx = hs * HXW'(p4_r.t.nx);
    p5_nxt.hy = hs * HXW'(p4_r.t.ny);
  end

  // Output stage: apply shifts or pass through, saturate
  always_comb begin
    logic signed [SW-1:0] hx, hy, ix, iy;
    pcr_in_t pl;
    pl = p5_r.t.pl;
    hx = SW'(p5_r.hx >>> F);
    hy = SW'(p5_r.hy >>> F);
    ix = SW'(p5_r.ix >>> F);
    iy = SW'(p5_r.iy >>> F);
    out_nxt.hit = p5_r.t.hit;
    if (p5_r.t.hit) begin
      out_nxt.a_new_pos_x  = sat32(SW'(pl.a_pos_x) + hx);
      out_nxt.a_new_pos_y  = sat32(SW'(pl.a_pos_y) + hy);
      out_nxt.a_new_prev_x = sat32(SW'(pl.a_prev_x) - ix);
      out_nxt.a_new_prev_y = sat32(SW'(pl.a_prev_y) - iy);
      out_nxt.b_new_pos_x  = sat32(SW'(pl.b_pos_x) - hx);
      out_nxt.b_new_pos_y  = sat32(SW'(pl.b_pos_y) - hy);
      out_nxt.b_new_prev_x = sat32(SW'(pl.b_prev_x) + ix);
      out_nxt.b_new_prev_y = sat32(SW'(pl.b_prev_y) + iy);
    end else begin
      out_nxt.a_new_pos_x  = pl.a_pos_x;
      out_nxt.a_new_pos_y  = pl.a_pos_y;
      out_nxt.a_new_prev_x = pl.a_prev_x;
      out_nxt.a_new_prev_y = pl.a_prev_y;
      out_nxt.b_new_pos_x  = pl.b_pos_x;
      out_nxt.b_new_pos_y  = pl.b_pos_y;
      out_nxt.b_new_prev_x = pl.b_prev_x;
      out_nxt.b_new_prev_y = pl.b_prev_y;
    end
  end

  // Payload registers: hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      p4_r  <= p4_nxt;
      p5_r  <= p5_nxt;
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  // A hit always comes from a near pair with a nonzero overlap
  a_hit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S4_I] && s4_r.hit |-> (s4_r.overlap != '0) && s4_r.c.near)
    else $error("hit without overlap");

  // Normal components never exceed one on a hit
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P0_I-1] && dv_r[DV_ST-1].hit |->
      (dv_r[DV_ST-1].qx <= {1'b1, {F{1'b0}}}) && (dv_r[DV_ST-1].qy <= {1'b1, {F{1'b0}}}))
    else $error("normal out of range");

  // A held pipeline keeps every valid bit
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during stall");
`endif

endmodule
